/* rtl/fpp2d_pkg.sv */
`timescale 1ns / 1ps
package fpp2d_pkg;

  // fixed field widths
  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQR_W    = 2 * COORD_W;
  localparam int SUMSQ_W  = 34;
  localparam int DIST_W   = 17;
  localparam int OIDX_W   = 6;
  localparam int REM_W    = DIST_W + 3;
  localparam int STEP_W   = 5;
  localparam int ROOT_STEPS = DIST_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [OIDX_W-1:0]         oidx_t;
  typedef logic [SUMSQ_W-1:0]        sumsq_t;

  // point as held in the store
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_DRAIN,
    ST_ROOT,
    ST_OUT
  } state_t;

endpackage

/* rtl/fpp2d_if.sv */
`timescale 1ns / 1ps
// point channel
interface fpp2d_in_if import fpp2d_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;
  logic   last_point;

  modport source (output valid, x_coord, y_coord, last_point, input ready);
  modport sink   (input valid, x_coord, y_coord, last_point, output ready);
endinterface

// result channel
interface fpp2d_out_if import fpp2d_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t max_distance;
  oidx_t first_index;
  oidx_t second_index;
  logic  overflowed;

  modport source (output valid, max_distance, first_index, second_index, overflowed,
                  input ready);
  modport sink   (input valid, max_distance, first_index, second_index, overflowed,
                  output ready);
endinterface

/* rtl/farthest_point_pair_2d_top.sv */
`timescale 1ns / 1ps
// Farthest pair of a 2D point set. Points enter one item per cycle, while
// in_ch.ready is high, into a store of MAX_POINTS entries; an item with
// last_point set is stored too and starts the search, and in_ch.ready stays
// low from then until the result is taken. The search walks every pair i<j
// in row-major order through one pipelined difference, square and compare
// unit fed by a two-port read of the store, one pair per cycle, and then
// drains that pipeline. A digit-by-digit square root unit then takes the root
// of the best squared distance, and the result is held on out_ch until taken.
// Points beyond MAX_POINTS are dropped and flagged as overflowed; with fewer
// than two points the result is all zero.
module farthest_point_pair_2d_top import fpp2d_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  fpp2d_in_if.sink    in_ch,
  fpp2d_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic [IDX_W-1:0] gen_i_r, gen_j_r;

  point_t           store_r [MAX_POINTS];
  point_t           rd_a_r, rd_b_r;

  logic             v1_r, v2_r, v3_r;
  logic [IDX_W-1:0] i1_r, j1_r, i2_r, j2_r, i3_r, j3_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [SQR_W-1:0] sqx_r, sqy_r;

  sumsq_t           best_sq_r;
  logic [IDX_W-1:0] best_i_r, best_j_r;

  sumsq_t           rad_r;
  logic [REM_W-1:0] rem_r;
  dist_t            root_r;
  logic [STEP_W-1:0] step_r;

  logic             in_acc, out_acc, full, last_j, last_i;
  logic [CNT_W-1:0] count_after;

  logic signed [2*DIFF_W-1:0] prodx, prody;
  sumsq_t           sum_sq;
  logic [REM_W-1:0] rem_sh, trial;
  logic [IDX_W+OIDX_W-1:0] oi_ext, oj_ext;

  // handshake and load bookkeeping
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign full        = (count_r == CNT_W'(MAX_POINTS));
  assign count_after = full ? count_r : count_r + CNT_W'(1);

  // end of row and end of search
  assign last_j = (CNT_W'(gen_j_r) == count_r - CNT_W'(1));
  assign last_i = (CNT_W'(gen_i_r) == count_r - CNT_W'(2));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_ch.last_point) begin
          state_nxt = (count_after < CNT_W'(2)) ? ST_ROOT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (last_j && last_i) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_LOAD);
  assign out_ch.valid = (state_r == ST_OUT);

  // point count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (in_acc) begin
      count_r <= count_after;
      if (full) begin
        ovf_r <= 1'b1;
      end
    end else if (out_acc) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end
  end

  // point store, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      store_r[count_r[IDX_W-1:0]] <= '{x: in_ch.x_coord, y: in_ch.y_coord};
    end
    rd_a_r <= store_r[gen_i_r];
    rd_b_r <= store_r[gen_j_r];
  end

  // pair index generator
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      gen_i_r <= '0;
      gen_j_r <= IDX_W'(1);
    end else if (state_r == ST_SEARCH) begin
      if (last_j) begin
        gen_i_r <= gen_i_r + IDX_W'(1);
        gen_j_r <= IDX_W'(CNT_W'(gen_i_r) + CNT_W'(2));
      end else begin
        gen_j_r <= gen_j_r + IDX_W'(1);
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= (state_r == ST_SEARCH);
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // difference and square stages
  assign prodx = dx_r * dx_r;
  assign prody = dy_r * dy_r;

  always_ff @(posedge clk) begin
    i1_r  <= gen_i_r;
    j1_r  <= gen_j_r;
    i2_r  <= i1_r;
    j2_r  <= j1_r;
    i3_r  <= i2_r;
    j3_r  <= j2_r;
    dx_r  <= DIFF_W'(rd_a_r.x) - DIFF_W'(rd_b_r.x);
    dy_r  <= DIFF_W'(rd_a_r.y) - DIFF_W'(rd_b_r.y);
    sqx_r <= prodx[SQR_W-1:0];
    sqy_r <= prody[SQR_W-1:0];
  end

  // sum and compare, strictly larger keeps the earliest pair on a tie
  assign sum_sq = SUMSQ_W'(sqx_r) + SUMSQ_W'(sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_sq_r <= '0;
      best_i_r  <= '0;
      best_j_r  <= '0;
    end else if (in_acc || out_acc) begin
      best_sq_r <= '0;
      best_i_r  <= '0;
      best_j_r  <= '0;
    end else if (v3_r && (sum_sq > best_sq_r)) begin
      best_sq_r <= sum_sq;
      best_i_r  <= i3_r;
      best_j_r  <= j3_r;
    end
  end

  // square root, two radicand bits per step
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SUMSQ_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD || state_r == ST_DRAIN) begin
      rad_r  <= (state_r == ST_DRAIN) ? best_sq_r : '0;
      rem_r  <= '0;
      root_r <= '0;
      step_r <= '0;
    end else if (state_r == ST_ROOT) begin
      rad_r  <= {rad_r[SUMSQ_W-3:0], 2'b00};
      step_r <= step_r + STEP_W'(1);
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[DIST_W-2:0], 1'b0};
      end
    end
  end

  // result fields, indices in their low bits
  assign oi_ext = {{OIDX_W{1'b0}}, best_i_r};
  assign oj_ext = {{OIDX_W{1'b0}}, best_j_r};

  assign out_ch.max_distance = root_r;
  assign out_ch.first_index  = oi_ext[OIDX_W-1:0];
  assign out_ch.second_index = oj_ext[OIDX_W-1:0];
  assign out_ch.overflowed   = ovf_r;

endmodule

/* rtl/fpp2d_checker.sv */
`timescale 1ns / 1ps
module fpp2d_checker import fpp2d_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  in_last_point,
  input logic  out_valid,
  input logic  out_ready,
  input dist_t out_max_distance,
  input oidx_t out_first_index,
  input oidx_t out_second_index,
  input logic  out_overflowed
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_distance) &&
      $stable(out_first_index) && $stable(out_second_index) && $stable(out_overflowed))
    else $error("result changed while stalled");

  // one set at a time: no loading while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("loading while a result is pending");

  // the closing point of a set stops loading
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_point |=> !in_ready)
    else $error("still loading after the last point");

  // a taken result reopens loading
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("not back to loading after result");

  // zero distance only with the default pair
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_max_distance == '0) |->
      (out_first_index == '0) && (out_second_index == '0))
    else $error("pair reported with zero distance");

endmodule

bind farthest_point_pair_2d_top fpp2d_checker u_fpp2d_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_last_point    (in_ch.last_point),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_max_distance (out_ch.max_distance),
  .out_first_index  (out_ch.first_index),
  .out_second_index (out_ch.second_index),
  .out_overflowed   (out_ch.overflowed)
);
